[hdl/snat_pkg.sv]
package snat_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int NAME_BITS   = 64;
    localparam int ADDR_BITS   = 32;
    localparam int LEN_BITS    = 6;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_DUP      = 3'd2,
        ST_BAD_PFX  = 3'd3,
        ST_FULL     = 3'd4,
        ST_ZERO_SRC = 3'd5,
        ST_NOT_IPV4 = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] src;
        logic [LEN_BITS-1:0]  slen;
        logic [ADDR_BITS-1:0] dst;
        logic [LEN_BITS-1:0]  dlen;
        logic [ADDR_BITS-1:0] gw;
        logic [NAME_BITS-1:0] name;
        logic [NAME_BITS-1:0] mask;
    } rule_t;

    typedef struct packed {
        logic                 we;
        logic [SLOT_BITS-1:0] waddr;
        logic [SLOT_BITS-1:0] raddr;
    } mem_ctl_t;

    function automatic logic [ADDR_BITS-1:0] len_mask(input logic [LEN_BITS-1:0] len);
        logic [ADDR_BITS-1:0] m;
        if (len == '0) begin
            m = '0;
        end else begin
            m = {ADDR_BITS{1'b1}} << (6'(ADDR_BITS) - len);
        end
        return m;
    endfunction

    function automatic logic [LEN_BITS-1:0] sat_len(input logic [LEN_BITS-1:0] v);
        return (v > LEN_BITS'(ADDR_BITS)) ? LEN_BITS'(ADDR_BITS) : v;
    endfunction

endpackage

[hdl/snat_rule_classifier.sv]
// source-nat rule classifier: keeps up to TABLE_DEPTH rules in one synchronous
// memory. a clear, an unknown command, a refused insert and a lookup with the
// ipv4 flag low are answered straight from the idle state. a lookup, a
// duplicate and a full insert read every filled slot once through the single
// read port; an insert that is added then goes on through S_WRITE to write the
// rule. one item is in work at a time; the result word sits in an output
// register and the next word is taken in the cycle after the result is handed
// over. the winner is the longest source prefix, then the longest destination
// prefix, then the newest slot.
module snat_rule_classifier
    import snat_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], src_addr[33:2], src_len[39:34], dst_addr[71:40],
    // dst_len[77:72], gateway_addr[109:78], dev_present[110],
    // dev_name[174:111], dev_mask[238:175], zero fill to 240
    input  logic [239:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], hit_slot[8:3], hit_gateway[40:9], zero fill to 48
    output logic [47:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);

    state_t state_reg, state_next;
    logic   ipv4_reg;
    logic [CNT_BITS-1:0]  fill_reg, fill_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;     // next slot to read
    logic                 rv_reg, rv_next;       // read data valid this cycle
    logic [SLOT_BITS-1:0] rslot_reg, rslot_next; // slot of read data
    logic                 best_v_reg, best_v_next;
    logic [SLOT_BITS-1:0] best_reg, best_next;
    logic [LEN_BITS-1:0]  bsl_reg, bsl_next, bdl_reg, bdl_next;
    logic [ADDR_BITS-1:0] bgw_reg, bgw_next;
    cmd_t                 cmd_reg, cmd_next;
    rule_t                req_reg, req_next;
    logic                 hasdev_reg, hasdev_next;
    logic                 ovalid_reg, ovalid_next;
    logic [47:0]          odata_reg, odata_next;

    rule_t    rd;
    mem_ctl_t ctl;
    logic     hit;
    rule_t    in_rule;
    logic     in_hasdev;

    assign in_rule.src  = s_tdata[33:2];
    assign in_rule.slen = sat_len(s_tdata[39:34]);
    assign in_rule.dst  = s_tdata[71:40];
    assign in_rule.dlen = sat_len(s_tdata[77:72]);
    assign in_rule.gw   = s_tdata[109:78];
    assign in_hasdev    = s_tdata[110];
    assign in_rule.name = s_tdata[174:111];
    assign in_rule.mask = s_tdata[238:175];

    snat_rule_mem u_mem (
        .aclk  (aclk),
        .ctl   (ctl),
        .wdata (req_reg),
        .rdata (rd)
    );

    snat_match u_match (
        .r        (rd),
        .src      (req_reg.src),
        .slen     (req_reg.slen),
        .dst      (req_reg.dst),
        .gw       (req_reg.gw),
        .has_dev  (cmd_reg == CMD_INSERT ? 1'b1 : hasdev_reg),
        .dev      (req_reg.name),
        .dup_mode (cmd_reg == CMD_INSERT),
        .hit      (hit)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = odata_reg;

    function automatic logic [47:0] pack_out(input status_t st,
                                             input logic [SLOT_BITS-1:0] sl,
                                             input logic [ADDR_BITS-1:0] g);
        return {7'd0, g, sl, st};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ipv4_reg   <= 1'b1;
            fill_reg   <= '0;
            ovalid_reg <= 1'b0;
            rv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            ovalid_reg <= ovalid_next;
            rv_reg     <= rv_next;
            if (cfg_valid && cfg_ready) begin
                ipv4_reg <= cfg_data;
            end
        end
        idx_reg    <= idx_next;
        rslot_reg  <= rslot_next;
        best_v_reg <= best_v_next;
        best_reg   <= best_next;
        bsl_reg    <= bsl_next;
        bdl_reg    <= bdl_next;
        bgw_reg    <= bgw_next;
        cmd_reg    <= cmd_next;
        req_reg    <= req_next;
        hasdev_reg <= hasdev_next;
        odata_reg  <= odata_next;
    end

    always_comb begin
        logic better;
        state_next  = state_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        rv_next     = 1'b0;
        rslot_next  = idx_reg[SLOT_BITS-1:0];
        best_v_next = best_v_reg;
        best_next   = best_reg;
        bsl_next    = bsl_reg;
        bdl_next    = bdl_reg;
        bgw_next    = bgw_reg;
        cmd_next    = cmd_reg;
        req_next    = req_reg;
        hasdev_next = hasdev_reg;
        odata_next  = odata_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ctl.we      = 1'b0;
        ctl.waddr   = fill_reg[SLOT_BITS-1:0];
        ctl.raddr   = idx_reg[SLOT_BITS-1:0];

        // compare the word that came out of memory against the running best
        better = !best_v_reg || (rd.slen != bsl_reg ? rd.slen > bsl_reg
                                                    : rd.dlen >= bdl_reg);
        if (rv_reg && hit && better) begin
            best_v_next = 1'b1;
            best_next   = rslot_reg;
            bsl_next    = rd.slen;
            bdl_next    = rd.dlen;
            bgw_next    = rd.gw;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd_next    = cmd_t'(s_tdata[1:0]);
                    req_next    = in_rule;
                    hasdev_next = in_hasdev;
                    idx_next    = '0;
                    best_v_next = 1'b0;
                    unique case (cmd_t'(s_tdata[1:0]))
                        CMD_CLEAR: begin
                            fill_next   = '0;
                            odata_next  = pack_out(ST_HIT, '0, '0);
                            ovalid_next = 1'b1;
                        end
                        CMD_INSERT: begin
                            if (in_rule.src == '0) begin
                                odata_next  = pack_out(ST_ZERO_SRC, '0, '0);
                                ovalid_next = 1'b1;
                            end else if ((in_rule.src & ~len_mask(in_rule.slen)) != '0) begin
                                odata_next  = pack_out(ST_BAD_PFX, '0, '0);
                                ovalid_next = 1'b1;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (!ipv4_reg) begin
                                odata_next  = pack_out(ST_NOT_IPV4, '0, '0);
                                ovalid_next = 1'b1;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_NONE: begin
                            odata_next  = pack_out(ST_MISS, '0, '0);
                            ovalid_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (idx_reg < fill_reg) begin
                    rv_next  = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end else begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (cmd_reg == CMD_LOOKUP) begin
                    odata_next = best_v_reg ? pack_out(ST_HIT, best_reg, bgw_reg)
                                            : pack_out(ST_MISS, '0, '0);
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end else if (best_v_reg) begin
                    odata_next  = pack_out(ST_DUP, best_reg, bgw_reg);
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end else if (fill_reg >= CNT_BITS'(TABLE_DEPTH)) begin
                    odata_next  = pack_out(ST_FULL, '0, '0);
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                ctl.we      = 1'b1;
                fill_next   = fill_reg + 1'b1;
                odata_next  = pack_out(ST_HIT, fill_reg[SLOT_BITS-1:0], req_reg.gw);
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[hdl/snat_rule_mem.sv]
module snat_rule_mem
    import snat_pkg::*;
(
    input  logic     aclk,
    input  mem_ctl_t ctl,
    input  rule_t    wdata,
    output rule_t    rdata
);

    rule_t mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= wdata;
        end
        rdata <= mem[ctl.raddr];
    end

endmodule

[hdl/snat_match.sv]
module snat_match
    import snat_pkg::*;
(
    input  rule_t                r,
    input  logic [ADDR_BITS-1:0] src,
    input  logic [LEN_BITS-1:0]  slen,
    input  logic [ADDR_BITS-1:0] dst,
    input  logic [ADDR_BITS-1:0] gw,
    input  logic                 has_dev,
    input  logic [NAME_BITS-1:0] dev,
    input  logic                 dup_mode,
    output logic                 hit
);

    logic m_src, m_dst, m_if;

    always_comb begin
        m_src = (src & len_mask(sat_len(r.slen))) == r.src;
        m_dst = (dst & len_mask(sat_len(r.dlen))) == r.dst;
        if (r.mask[7:0] != 8'd0) begin
            m_if = has_dev && (((dev ^ r.name) & r.mask) == '0);
        end else begin
            m_if = (r.gw == '0) || (r.gw == gw);
        end
        hit = m_src && m_dst && m_if;
        if (dup_mode && ((r.src != src) || (r.slen != slen))) begin
            hit = 1'b0;
        end
    end

endmodule

[hdl/snat_checker.sv]
module snat_checker
    import snat_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] != 3'd7)
        else $error("bad status code");

    a_noslot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_HIT && m_tdata[2:0] != ST_DUP
        |-> m_tdata[40:3] == '0)
        else $error("slot reported without rule");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("took a second word while busy");

endmodule

bind snat_rule_classifier snat_checker u_snat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
